/* hdl/lkv_pkg.sv */
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants for the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int KEY_BITS_DEF    = 16;
  localparam int VALUE_BITS_DEF  = 32;

  localparam int             CAP_BITS  = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE,
    ST_REPLY
  } state_t;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic update;
    logic reply;
  } ctl_cmd_t;

endpackage

/* hdl/lkv_if.sv */
// ----------------------------------------------------------------------------
// lkv_if
// Request and response channels of the LRU key-value cache.
// ----------------------------------------------------------------------------
interface lkv_req_if #(
  parameter int KEY_BITS   = lkv_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lkv_pkg::VALUE_BITS_DEF
);
  import lkv_pkg::*;

  logic                  valid;
  logic                  ready;
  cmd_t                  command;
  logic [KEY_BITS-1:0]   lookup_key;
  logic [VALUE_BITS-1:0] write_value;

  modport source (output valid, command, lookup_key, write_value, input ready);
  modport sink   (input valid, command, lookup_key, write_value, output ready);
endinterface

interface lkv_rsp_if #(
  parameter int KEY_BITS   = lkv_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lkv_pkg::VALUE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [VALUE_BITS-1:0] read_value;
  logic                  evicted;
  logic [KEY_BITS-1:0]   evicted_key;

  modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
  modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

/* hdl/lkv_ram.sv */
// ----------------------------------------------------------------------------
// lkv_ram
// Simple dual-port RAM, registered read, read-first on address collision.
// ----------------------------------------------------------------------------
module lkv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/lkv_ctrl.sv */
// ----------------------------------------------------------------------------
// lkv_ctrl
// Item sequencer: capture, lookup, update, reply; owns the handshakes.
// ----------------------------------------------------------------------------
module lkv_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output lkv_pkg::ctl_cmd_t cmd
);
  import lkv_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_MATCH;
        end
      end
      ST_MATCH: begin
        cmd.lookup = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_REPLY;
      end
      ST_REPLY: begin
        if (!out_valid || out_ready) begin
          cmd.reply  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.reply) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* hdl/lkv_datapath.sv */
// ----------------------------------------------------------------------------
// lkv_datapath
// Key cells, recency ranks, valid bits, key/value RAMs and result register.
// ----------------------------------------------------------------------------
module lkv_datapath #(
  parameter int MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEF,
  parameter int KEY_BITS    = lkv_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS  = lkv_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [lkv_pkg::CAP_BITS-1:0]  cfg_write_data,
  input  lkv_pkg::ctl_cmd_t             cmd,
  input  lkv_pkg::cmd_t                 in_command,
  input  logic [KEY_BITS-1:0]           in_key,
  input  logic [VALUE_BITS-1:0]         in_value,
  output logic                          out_hit,
  output logic [VALUE_BITS-1:0]         out_read_value,
  output logic                          out_evicted,
  output logic [KEY_BITS-1:0]           out_evicted_key
);
  import lkv_pkg::*;

  localparam int IW  = $clog2(MAX_ENTRIES);
  localparam int CW  = $clog2(MAX_ENTRIES + 1);
  localparam int CXW = (CW > CAP_BITS) ? CW : CAP_BITS;

  logic [CAP_BITS-1:0]   cap_reg;
  cmd_t                  cmd_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;

  logic                  slot_valid [MAX_ENTRIES];
  logic [KEY_BITS-1:0]   slot_key   [MAX_ENTRIES];
  logic [IW-1:0]         slot_rank  [MAX_ENTRIES];
  logic [CW-1:0]         used_count;

  logic                  match_any;
  logic [IW-1:0]         hit_idx;
  logic [IW-1:0]         hit_rank;
  logic [IW-1:0]         lru_idx;
  logic [IW-1:0]         free_idx;
  logic [CXW-1:0]        cap_ext;
  logic [CXW-1:0]        eff_cap;
  logic                  need_evict;

  logic                  hit_q;
  logic [IW-1:0]         hit_idx_q;
  logic [IW-1:0]         hit_rank_q;
  logic [IW-1:0]         lru_idx_q;
  logic [IW-1:0]         free_idx_q;
  logic                  evict_q;
  logic [IW-1:0]         target;
  logic                  is_put;
  logic                  put_miss;

  logic                  vram_we;
  logic [IW-1:0]         vram_waddr;
  logic [VALUE_BITS-1:0] vram_rdata;
  logic [KEY_BITS-1:0]   kram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg <= CAP_RESET;
    end else if (cfg_write_en) begin
      cap_reg <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_q <= in_command;
      key_q <= in_key;
      val_q <= in_value;
    end
  end

  // parallel compare; lowest-index priority for free slot
  always_comb begin
    match_any = 1'b0;
    hit_idx   = '0;
    hit_rank  = '0;
    lru_idx   = '0;
    free_idx  = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (slot_valid[i] && slot_key[i] == key_q) begin
        match_any = 1'b1;
        hit_idx   = IW'(i);
        hit_rank  = hit_rank | slot_rank[i];
      end
      if (slot_valid[i] && CW'(slot_rank[i]) == used_count - CW'(1)) begin
        lru_idx = IW'(i);
      end
      if (!slot_valid[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  always_comb begin
    cap_ext = CXW'(cap_reg);
    if (cap_ext == '0) begin
      eff_cap = CXW'(1);
    end else if (cap_ext > CXW'(MAX_ENTRIES)) begin
      eff_cap = CXW'(MAX_ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
    need_evict = CXW'(used_count) >= eff_cap;
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      hit_q      <= match_any;
      hit_idx_q  <= hit_idx;
      hit_rank_q <= hit_rank;
      lru_idx_q  <= lru_idx;
      free_idx_q <= free_idx;
      evict_q    <= need_evict;
    end
  end

  assign is_put   = (cmd_q == CMD_PUT);
  assign put_miss = is_put && !hit_q;
  assign target   = evict_q ? lru_idx_q : free_idx_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        slot_valid[i] <= 1'b0;
      end
      used_count <= '0;
    end else if (cmd.update && put_miss) begin
      slot_valid[target] <= 1'b1;
      if (!evict_q) begin
        used_count <= used_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (hit_q) begin
          if (IW'(i) == hit_idx_q) begin
            slot_rank[i] <= '0;
          end else if (slot_valid[i] && slot_rank[i] < hit_rank_q) begin
            slot_rank[i] <= slot_rank[i] + IW'(1);
          end
        end else if (is_put) begin
          if (IW'(i) == target) begin
            slot_rank[i] <= '0;
            slot_key[i]  <= key_q;
          end else if (slot_valid[i]) begin
            slot_rank[i] <= slot_rank[i] + IW'(1);
          end
        end
      end
    end
  end

  assign vram_we    = cmd.update && is_put;
  assign vram_waddr = hit_q ? hit_idx_q : target;

  lkv_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_ENTRIES)
  ) u_value_ram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (vram_waddr),
    .wdata (val_q),
    .re    (cmd.update),
    .raddr (hit_idx_q),
    .rdata (vram_rdata)
  );

  // read-first: evicted key comes out while the new key lands in the same slot
  lkv_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (MAX_ENTRIES)
  ) u_key_ram (
    .clk   (clk),
    .we    (cmd.update && put_miss),
    .waddr (target),
    .wdata (key_q),
    .re    (cmd.update),
    .raddr (lru_idx_q),
    .rdata (kram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.reply) begin
      out_hit         <= hit_q;
      out_read_value  <= (!is_put && hit_q) ? vram_rdata : '0;
      out_evicted     <= put_miss && evict_q;
      out_evicted_key <= (put_miss && evict_q) ? kram_rdata : '0;
    end
  end

endmodule

/* hdl/lru_key_value_cache.sv */
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Timing: a request is accepted in the idle state, then passes the compare,
//   update and reply states before its result is registered valid; a new item
//   is taken only back in idle, and a stalled result holds it in the reply state.
// Reset: synchronous; clears valid bits and entry count, capacity back to 16.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
  parameter int MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEF,
  parameter int KEY_BITS    = lkv_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS  = lkv_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write_en,
  input  logic [lkv_pkg::CAP_BITS-1:0] cfg_write_data,
  lkv_req_if.sink                      req,
  lkv_rsp_if.source                    rsp
);
  import lkv_pkg::*;

  ctl_cmd_t cmd;

  lkv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  lkv_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .KEY_BITS    (KEY_BITS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_write_en    (cfg_write_en),
    .cfg_write_data  (cfg_write_data),
    .cmd             (cmd),
    .in_command      (req.command),
    .in_key          (req.lookup_key),
    .in_value        (req.write_value),
    .out_hit         (rsp.hit),
    .out_read_value  (rsp.read_value),
    .out_evicted     (rsp.evicted),
    .out_evicted_key (rsp.evicted_key)
  );

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LRU key-value cache: a queue-fed request driver
// with bursty pacing, a response monitor with a pattern-driven stall, and an
// in-bench LRU predictor. Runs directed corner cases, then random get/put
// traffic over small key pools under a range of capacity settings.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lkv_pkg::*;

  localparam int NENT = MAX_ENTRIES_DEF;
  localparam int KW   = KEY_BITS_DEF;
  localparam int VW   = VALUE_BITS_DEF;
  localparam int N_PHASES = 11;
  localparam int PHASE_ITEMS = 167;
  localparam logic [CAP_BITS-1:0] CAP_PLAN [0:N_PHASES-1] =
    '{5'd16, 5'd1, 5'd4, 5'd31, 5'd0, 5'd8, 5'd3, 5'd16, 5'd12, 5'd2, 5'd6};

  typedef struct packed {
    cmd_t          command;
    logic [KW-1:0] key;
    logic [VW-1:0] value;
  } cache_req_t;

  typedef struct packed {
    logic          hit;
    logic [VW-1:0] read_value;
    logic          evicted;
    logic [KW-1:0] evicted_key;
  } cache_rsp_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write_en;
  logic [CAP_BITS-1:0] cfg_write_data;

  lkv_req_if req_ch();
  lkv_rsp_if rsp_ch();

  lru_key_value_cache u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .req            (req_ch),
    .rsp            (rsp_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic                ent_valid [NENT];
  logic [KW-1:0]       ent_key   [NENT];
  logic [VW-1:0]       ent_value [NENT];
  int                  ent_rank  [NENT];
  int                  ent_count;
  logic [CAP_BITS-1:0] cap_setting;

  cache_req_t pending_reqs[$];
  cache_rsp_t expected_replies[$];
  cache_req_t next_req;

  int items_queued, items_taken, fail_count;
  int n_puts, n_hits, n_evicts, n_caps;
  logic req_took;

  int max_burst, max_gap, burst_left, gap_left;
  logic [31:0] rdy_pattern;
  logic [4:0]  rdy_pos;
  logic [KW-1:0] key_pool [32];

  function automatic cache_rsp_t lru_apply(cache_req_t rq);
    cache_rsp_t r;
    int i, found, target, lim, old_rank, best;
    r = '0;
    found = -1;
    target = -1;
    for (i = 0; i < NENT; i++) begin
      if (found < 0 && ent_valid[i] && ent_key[i] == rq.key) found = i;
    end
    if (found >= 0) begin
      r.hit = 1'b1;
      if (rq.command == CMD_PUT) ent_value[found] = rq.value;
      else r.read_value = ent_value[found];
      old_rank = ent_rank[found];
      for (i = 0; i < NENT; i++) begin
        if (ent_valid[i] && i != found && ent_rank[i] < old_rank) ent_rank[i]++;
      end
      ent_rank[found] = 0;
      return r;
    end
    if (rq.command == CMD_GET) return r;
    lim = (cap_setting == 0) ? 1 : (cap_setting > NENT) ? NENT : int'(cap_setting);
    if (ent_count >= lim) begin
      best = 0;
      for (i = 0; i < NENT; i++) begin
        if (ent_valid[i] && (target < 0 || ent_rank[i] > best)) begin
          target = i;
          best = ent_rank[i];
        end
      end
      if (target >= 0) begin
        r.evicted = 1'b1;
        r.evicted_key = ent_key[target];
        ent_valid[target] = 1'b0;
        ent_count--;
      end
    end
    if (target < 0) begin
      for (i = NENT - 1; i >= 0; i--) begin
        if (!ent_valid[i]) target = i;
      end
    end
    for (i = 0; i < NENT; i++) begin
      if (ent_valid[i]) ent_rank[i]++;
    end
    ent_valid[target] = 1'b1;
    ent_key[target] = rq.key;
    ent_value[target] = rq.value;
    ent_rank[target] = 0;
    ent_count++;
    return r;
  endfunction

  task automatic flag_field(string field, logic [VW-1:0] want, logic [VW-1:0] got);
    fail_count++;
    if (fail_count <= 40)
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
  endtask

  // request driver and response stall pattern
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= rdy_pattern[rdy_pos];
      rdy_pos <= rdy_pos + 5'd1;
      if (!req_ch.valid || req_took) begin
        if (gap_left > 0) begin
          req_ch.valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_reqs.size() != 0) begin
          next_req = pending_reqs.pop_front();
          req_ch.valid       <= 1'b1;
          req_ch.command     <= next_req.command;
          req_ch.lookup_key  <= next_req.key;
          req_ch.write_value <= next_req.value;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, max_burst);
            gap_left   <= $urandom_range(0, max_gap);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // request capture, prediction and result check
  always @(posedge clk) begin
    cache_req_t rq;
    cache_rsp_t want, got;
    if (rst) begin
      req_took <= 1'b0;
    end else begin
      req_took <= req_ch.valid && req_ch.ready;
      if (cfg_write_en) begin
        cap_setting = cfg_write_data;
        n_caps++;
      end
      if (req_ch.valid && req_ch.ready) begin
        rq.command = req_ch.command;
        rq.key     = req_ch.lookup_key;
        rq.value   = req_ch.write_value;
        want = lru_apply(rq);
        expected_replies.push_back(want);
        items_taken++;
        if (rq.command == CMD_PUT) n_puts++;
        if (want.hit) n_hits++;
        if (want.evicted) n_evicts++;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.hit         = rsp_ch.hit;
        got.read_value  = rsp_ch.read_value;
        got.evicted     = rsp_ch.evicted;
        got.evicted_key = rsp_ch.evicted_key;
        if (expected_replies.size() == 0) begin
          fail_count++;
          if (fail_count <= 40)
            $display("%0t ns: unexpected result, expected none, actual 0x%0h", $time, got);
        end else begin
          want = expected_replies.pop_front();
          if (got.hit !== want.hit) flag_field("hit", VW'(want.hit), VW'(got.hit));
          if (got.read_value !== want.read_value)
            flag_field("read_value", want.read_value, got.read_value);
          if (got.evicted !== want.evicted)
            flag_field("evicted", VW'(want.evicted), VW'(got.evicted));
          if (got.evicted_key !== want.evicted_key)
            flag_field("evicted_key", VW'(want.evicted_key), VW'(got.evicted_key));
        end
      end
    end
  end

  task automatic queue_item(cmd_t c, logic [KW-1:0] k, logic [VW-1:0] v);
    cache_req_t it;
    it.command = c;
    it.key = k;
    it.value = v;
    pending_reqs.push_back(it);
    items_queued++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (items_taken != items_queued || expected_replies.size() != 0);
  endtask

  task automatic write_capacity(logic [CAP_BITS-1:0] v);
    @(negedge clk);
    cfg_write_data <= v;
    cfg_write_en   <= 1'b1;
    @(negedge clk);
    cfg_write_en   <= 1'b0;
  endtask

  task automatic set_pacing(int style);
    case (style)
      0: begin
        max_burst = 64; max_gap = 0; rdy_pattern = '1;
      end
      1: begin
        max_burst = 4; max_gap = 3; rdy_pattern = $urandom;
      end
      2: begin
        max_burst = 2; max_gap = 8; rdy_pattern = $urandom & $urandom;
      end
      default: begin
        max_burst = 16; max_gap = 1; rdy_pattern = $urandom & $urandom;
      end
    endcase
    if (rdy_pattern == '0) rdy_pattern = 32'h1;
  endtask

  task automatic queue_random(int count, int span);
    int k;
    logic [KW-1:0] key;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) == 0) key = KW'($urandom);
      else key = key_pool[$urandom_range(0, span - 1)];
      queue_item(cmd_t'($urandom_range(0, 1)), key, $urandom);
    end
  endtask

  initial begin
    int p, i, eff, span;
    rst = 1'b1;
    cfg_write_en = 1'b0;
    cfg_write_data = '0;
    req_ch.valid = 1'b0;
    req_ch.command = CMD_GET;
    req_ch.lookup_key = '0;
    req_ch.write_value = '0;
    rsp_ch.ready = 1'b0;
    rdy_pos = '0;
    burst_left = 0;
    gap_left = 0;
    items_queued = 0;
    items_taken = 0;
    fail_count = 0;
    n_puts = 0; n_hits = 0; n_evicts = 0; n_caps = 0;
    for (i = 0; i < NENT; i++) begin
      ent_valid[i] = 1'b0;
      ent_key[i] = '0;
      ent_value[i] = '0;
      ent_rank[i] = 0;
    end
    ent_count = 0;
    cap_setting = CAP_RESET;
    set_pacing(0);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty get, extremes, put update, misses
    queue_item(CMD_GET, 16'h0000, 32'h0000_0000);
    queue_item(CMD_PUT, 16'h0000, 32'h0000_0000);
    queue_item(CMD_PUT, 16'hFFFF, 32'hFFFF_FFFF);
    queue_item(CMD_GET, 16'h0000, 32'hFFFF_FFFF);
    queue_item(CMD_GET, 16'hFFFF, 32'h0000_0000);
    queue_item(CMD_PUT, 16'h0000, 32'hA5A5_5A5A);
    queue_item(CMD_GET, 16'h0000, 32'h0);
    queue_item(CMD_GET, 16'h1234, 32'h0);
    wait_drained();

    // tight capacity: eviction of the least recently used entry
    write_capacity(5'd2);
    queue_item(CMD_PUT, 16'h00FF, 32'h1357_9BDF);
    queue_item(CMD_GET, 16'hFFFF, 32'h0);
    queue_item(CMD_PUT, 16'h0000, 32'h5A5A_A5A5);
    queue_item(CMD_PUT, 16'hFF00, 32'h8000_0001);
    queue_item(CMD_GET, 16'h00FF, 32'h0);
    wait_drained();

    // zero capacity acts as one, count already above it
    write_capacity(5'd0);
    queue_item(CMD_PUT, 16'h5555, 32'h5555_5555);
    queue_item(CMD_GET, 16'hFF00, 32'h0);
    queue_item(CMD_PUT, 16'hAAAA, 32'hAAAA_AAAA);
    queue_item(CMD_GET, 16'h5555, 32'h0);
    wait_drained();

    // out-of-range capacity acts as the maximum: free slots refill
    write_capacity(5'd31);
    queue_item(CMD_PUT, 16'h0001, 32'h0000_0001);
    queue_item(CMD_PUT, 16'h8000, 32'h7FFF_FFFF);
    queue_item(CMD_GET, 16'hAAAA, 32'h0);
    queue_item(CMD_GET, 16'h8000, 32'h0);
    wait_drained();

    for (p = 0; p < N_PHASES; p++) begin
      for (i = 0; i < 32; i++) key_pool[i] = KW'($urandom);
      eff = (CAP_PLAN[p] == 0) ? 1 : (CAP_PLAN[p] > NENT) ? NENT : int'(CAP_PLAN[p]);
      span = eff + 1 + $urandom_range(0, 5);
      if (span > 32) span = 32;
      set_pacing(p % 4);
      write_capacity(CAP_PLAN[p]);
      queue_random(PHASE_ITEMS / 2, span);
      // hold off until every outstanding result is back
      wait_drained();
      queue_random(PHASE_ITEMS - PHASE_ITEMS / 2, span);
      wait_drained();
    end

    repeat (12) @(negedge clk);
    $display("Covered %0d requests (%0d puts, %0d gets) over %0d capacity writes:",
             items_taken, n_puts, items_taken - n_puts, n_caps);
    $display("  %0d hits, %0d misses, %0d evictions", n_hits, items_taken - n_hits, n_evicts);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
